// ===== design/sprm_pkg.sv =====
package sprm_pkg;

  localparam int MAX_DATA_BYTES = 4;

  localparam int CMD_BITS   = 8;
  localparam int DATA_BITS  = 32;
  localparam int SHIFT_BITS = CMD_BITS + DATA_BITS;
  localparam int COUNT_BITS = 6;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] KIND_CMD_ONLY = 2'd0;
  localparam logic [1:0] KIND_WRITE    = 2'd1;
  localparam logic [1:0] KIND_READ     = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_COUNT = 2'd1;
  localparam logic [1:0] ERR_TYPE  = 2'd2;
  localparam logic [1:0] ERR_BUSY  = 2'd3;

  localparam logic [7:0] TYPE_MASK  = 8'hC0;
  localparam logic [7:0] TYPE_READ  = 8'h00;
  localparam logic [7:0] TYPE_WRITE = 8'h40;

  localparam logic [2:0] COUNT_SHORT = 3'd3;
  localparam logic [2:0] COUNT_LONG  = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  kind;
    logic [7:0]  command_byte;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        miso_level;
  } item_t;

  typedef struct packed {
    logic        chip_select_n;
    logic        serial_clock;
    logic        master_out;
    logic [31:0] read_data;
    logic        done_res;
    logic [1:0]  error_code;
  } result_t;

endpackage

// ===== design/spi_register_access_master_core.sv =====
// channel  handshake             payload
// in       in_valid / in_stall   cmd, kind, command_byte, write_data, byte_count, miso_level
// out      out_valid / out_stall chip_select_n, serial_clock, master_out, read_data,
//                                done_res, error_code
//
// one transaction per cycle sustained while the output is not stalled; the path from input to result
// is the input register, then single-pass update of the spi state into the result register
// rst is synchronous: idle, chip select high, clock high, data line low
// a stall on the output holds the result and backs up into in_stall in the same cycle
module spi_register_access_master_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [1:0]  kind,
  input  logic [7:0]  command_byte,
  input  logic [31:0] write_data,
  input  logic [2:0]  byte_count,
  input  logic        miso_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        chip_select_n,
  output logic        serial_clock,
  output logic        master_out,
  output logic [31:0] read_data,
  output logic        done_res,
  output logic [1:0]  error_code
);

  sprm_pkg::item_t   in_item;
  sprm_pkg::item_t   item;
  sprm_pkg::result_t result;
  sprm_pkg::result_t out_result;
  logic              item_valid;
  logic              free;
  logic              fire;

  assign in_item.cmd          = cmd;
  assign in_item.kind         = kind;
  assign in_item.command_byte = command_byte;
  assign in_item.write_data   = write_data;
  assign in_item.byte_count   = byte_count;
  assign in_item.miso_level   = miso_level;

  assign fire = item_valid && free;

  sprm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sprm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  sprm_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .result     (result),
    .free       (free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign chip_select_n = out_result.chip_select_n;
  assign serial_clock  = out_result.serial_clock;
  assign master_out    = out_result.master_out;
  assign read_data     = out_result.read_data;
  assign done_res      = out_result.done_res;
  assign error_code    = out_result.error_code;

endmodule

// ===== design/sprm_in_reg.sv =====
module sprm_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sprm_pkg::item_t in_item,
  input  logic           fire,
  output logic           item_valid,
  output sprm_pkg::item_t item
);

  logic accept;

  assign in_stall = item_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept || (item_valid && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/sprm_engine.sv =====
module sprm_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sprm_pkg::item_t   item,
  output sprm_pkg::result_t result
);

  logic                                busy, busy_next;
  logic                                clock_phase_high, clock_phase_high_next;
  logic [sprm_pkg::SHIFT_BITS-1:0]     out_shift, out_shift_next;
  logic [sprm_pkg::DATA_BITS-1:0]      in_shift, in_shift_next;
  logic [sprm_pkg::COUNT_BITS-1:0]     bits_left, bits_left_next;
  logic [sprm_pkg::COUNT_BITS-1:0]     read_bits_left, read_bits_left_next;
  logic                                data_line, data_line_next;
  logic                                is_read, is_read_next;
  logic                                count_ok;
  logic                                done;
  logic [1:0]                          err;
  logic [sprm_pkg::DATA_BITS-1:0]      rdata;
  logic [sprm_pkg::COUNT_BITS-1:0]     bit_index;
  logic [sprm_pkg::COUNT_BITS-1:0]     read_bits_load;

  assign count_ok = (item.byte_count == sprm_pkg::COUNT_SHORT ||
                     item.byte_count == sprm_pkg::COUNT_LONG) &&
                    ({1'b0, item.byte_count} <= 4'(sprm_pkg::MAX_DATA_BYTES));
  assign bit_index      = bits_left - 1'b1;
  assign read_bits_load = {item.byte_count, 3'b000};

  always_comb begin
    busy_next             = busy;
    clock_phase_high_next = clock_phase_high;
    out_shift_next        = out_shift;
    in_shift_next         = in_shift;
    bits_left_next        = bits_left;
    read_bits_left_next   = read_bits_left;
    data_line_next        = data_line;
    is_read_next          = is_read;
    done                  = 1'b0;
    err                   = sprm_pkg::ERR_OK;
    rdata                 = '0;

    if (item.cmd == sprm_pkg::CMD_START) begin
      priority if (busy) begin
        err = sprm_pkg::ERR_BUSY;
      end else if (item.kind == sprm_pkg::KIND_CMD_ONLY) begin
        out_shift_next      = {32'd0, item.command_byte};
        bits_left_next      = 6'(sprm_pkg::CMD_BITS);
        read_bits_left_next = '0;
        is_read_next        = 1'b0;
        in_shift_next       = '0;
        busy_next           = 1'b1;
      end else if (item.kind != sprm_pkg::KIND_WRITE && item.kind != sprm_pkg::KIND_READ) begin
        err  = sprm_pkg::ERR_TYPE;
        done = 1'b1;
      end else if (!count_ok) begin
        err  = sprm_pkg::ERR_COUNT;
        done = 1'b1;
      end else if (item.kind == sprm_pkg::KIND_WRITE) begin
        if ((item.command_byte & sprm_pkg::TYPE_MASK) != sprm_pkg::TYPE_WRITE) begin
          err  = sprm_pkg::ERR_TYPE;
          done = 1'b1;
        end else begin
          if (item.byte_count == sprm_pkg::COUNT_LONG) begin
            out_shift_next = {item.command_byte, item.write_data};
            bits_left_next = 6'd40;
          end else begin
            out_shift_next = {8'd0, item.command_byte, item.write_data[23:0]};
            bits_left_next = 6'd32;
          end
          read_bits_left_next = '0;
          is_read_next        = 1'b0;
          in_shift_next       = '0;
          busy_next           = 1'b1;
        end
      end else begin
        if ((item.command_byte & sprm_pkg::TYPE_MASK) != sprm_pkg::TYPE_READ) begin
          err  = sprm_pkg::ERR_TYPE;
          done = 1'b1;
        end else begin
          out_shift_next      = {32'd0, item.command_byte};
          bits_left_next      = 6'(sprm_pkg::CMD_BITS);
          read_bits_left_next = read_bits_load;
          is_read_next        = 1'b1;
          in_shift_next       = '0;
          busy_next           = 1'b1;
        end
      end
    end else if (busy) begin
      if (clock_phase_high) begin
        clock_phase_high_next = 1'b0;
        if (bits_left != '0) begin
          data_line_next = out_shift[bit_index];
        end else begin
          data_line_next = 1'b1;
        end
      end else begin
        clock_phase_high_next = 1'b1;
        if (bits_left != '0) begin
          bits_left_next = bit_index;
          if (bit_index == '0 && is_read) begin
            data_line_next = 1'b1;
          end
        end else if (read_bits_left != '0) begin
          in_shift_next       = {in_shift[sprm_pkg::DATA_BITS-2:0], item.miso_level};
          read_bits_left_next = read_bits_left - 1'b1;
        end
        if (bits_left_next == '0 && read_bits_left_next == '0) begin
          busy_next = 1'b0;
          done      = 1'b1;
          if (is_read) begin
            rdata = in_shift_next;
          end
        end
      end
    end
  end

  assign result.chip_select_n = !busy_next;
  assign result.serial_clock  = clock_phase_high_next;
  assign result.master_out    = data_line_next;
  assign result.read_data     = rdata;
  assign result.done_res      = done;
  assign result.error_code    = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      clock_phase_high <= 1'b1;
      out_shift        <= '0;
      in_shift         <= '0;
      bits_left        <= '0;
      read_bits_left   <= '0;
      data_line        <= 1'b0;
      is_read          <= 1'b0;
    end else if (fire) begin
      busy             <= busy_next;
      clock_phase_high <= clock_phase_high_next;
      out_shift        <= out_shift_next;
      in_shift         <= in_shift_next;
      bits_left        <= bits_left_next;
      read_bits_left   <= read_bits_left_next;
      data_line        <= data_line_next;
      is_read          <= is_read_next;
    end
  end

endmodule

// ===== design/sprm_out_reg.sv =====
module sprm_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  sprm_pkg::result_t result,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output sprm_pkg::result_t out_result
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

endmodule
